>>> rtl/core/hmo_pkg.sv
// Shared types, constants and the island color table of the heightmap overlay shader.
package hmo_pkg;

  // Register indexes on the configuration port (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_Z_MIN         = 3'd0,
    REG_Z_SCALE       = 3'd1,
    REG_FRAME_WIDTH   = 3'd2,
    REG_FRAME_HEIGHT  = 3'd3,
    REG_MARKER_X      = 3'd4,
    REG_MARKER_Y      = 3'd5,
    REG_MARKER_ENABLE = 3'd6
  } reg_idx_e;

  localparam int unsigned APB_ADDR_BITS = 5;
  localparam int unsigned APB_DATA_BITS = 32;

  localparam logic [15:0] Z_MIN_RST        = 16'd0;
  localparam logic [23:0] Z_SCALE_RST      = 24'd65536;
  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1;

  // Reciprocal of 60 used to split the island number: q = (id * 69905) >> 22 is
  // exact or one low for every 16-bit id.
  localparam logic [16:0] HUE_RECIP       = 17'd69905;
  localparam int unsigned HUE_RECIP_SHIFT = 22;
  localparam logic [6:0]  HUE_PERIOD      = 7'd60;

  localparam logic [7:0] ISLAND_RED  = 8'd242;
  localparam logic [7:0] ISLAND_BLUE = 8'd24;
  localparam logic [7:0] GRAY_MAX    = 8'd255;
  localparam logic [7:0] MARKER_RED   = 8'd0;
  localparam logic [7:0] MARKER_GREEN = 8'd255;
  localparam logic [7:0] MARKER_BLUE  = 8'd255;

  typedef struct packed {
    logic [15:0] z_min;
    logic [23:0] z_scale;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [11:0] marker_x;
    logic [11:0] marker_y;
    logic        marker_enable;
  } cfg_t;

  // Raster position flags for the pixel being accepted.
  typedef struct packed {
    logic marker_hit;
    logic frame_end;
  } scan_t;

  // Contents of the input register stage.
  typedef struct packed {
    logic [16:0] height_diff;
    logic        island_valid;
    logic [15:0] island_number;
    logic [10:0] hue_quot;
    scan_t       scan;
  } stage_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  // Island green channel indexed by island_number mod 60; the hue is (37 * id) mod 60
  // and green is floor(24.225 + 3.63375 * hue).
  function automatic logic [7:0] island_green(input logic [5:0] rem);
    logic [7:0] g;
    case (rem)
      6'd0:  g = 8'd24;   6'd1:  g = 8'd158;  6'd2:  g = 8'd75;   6'd3:  g = 8'd209;
      6'd4:  g = 8'd125;  6'd5:  g = 8'd42;   6'd6:  g = 8'd176;  6'd7:  g = 8'd93;
      6'd8:  g = 8'd227;  6'd9:  g = 8'd144;  6'd10: g = 8'd60;   6'd11: g = 8'd195;
      6'd12: g = 8'd111;  6'd13: g = 8'd27;   6'd14: g = 8'd162;  6'd15: g = 8'd78;
      6'd16: g = 8'd213;  6'd17: g = 8'd129;  6'd18: g = 8'd46;   6'd19: g = 8'd180;
      6'd20: g = 8'd96;   6'd21: g = 8'd231;  6'd22: g = 8'd147;  6'd23: g = 8'd64;
      6'd24: g = 8'd198;  6'd25: g = 8'd115;  6'd26: g = 8'd31;   6'd27: g = 8'd165;
      6'd28: g = 8'd82;   6'd29: g = 8'd216;  6'd30: g = 8'd133;  6'd31: g = 8'd49;
      6'd32: g = 8'd184;  6'd33: g = 8'd100;  6'd34: g = 8'd234;  6'd35: g = 8'd151;
      6'd36: g = 8'd67;   6'd37: g = 8'd202;  6'd38: g = 8'd118;  6'd39: g = 8'd35;
      6'd40: g = 8'd169;  6'd41: g = 8'd85;   6'd42: g = 8'd220;  6'd43: g = 8'd136;
      6'd44: g = 8'd53;   6'd45: g = 8'd187;  6'd46: g = 8'd104;  6'd47: g = 8'd238;
      6'd48: g = 8'd155;  6'd49: g = 8'd71;   6'd50: g = 8'd205;  6'd51: g = 8'd122;
      6'd52: g = 8'd38;   6'd53: g = 8'd173;  6'd54: g = 8'd89;   6'd55: g = 8'd224;
      6'd56: g = 8'd140;  6'd57: g = 8'd56;   6'd58: g = 8'd191;  6'd59: g = 8'd107;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

>>> rtl/core/hmo_cfg.sv
// Configuration register file behind the APB-style port.
module hmo_cfg import hmo_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_Z_MIN:         cfg_d.z_min         = pwdata[15:0];
        REG_Z_SCALE:       cfg_d.z_scale       = pwdata[23:0];
        REG_FRAME_WIDTH:   cfg_d.frame_width   = pwdata[12:0];
        REG_FRAME_HEIGHT:  cfg_d.frame_height  = pwdata[12:0];
        REG_MARKER_X:      cfg_d.marker_x      = pwdata[11:0];
        REG_MARKER_Y:      cfg_d.marker_y      = pwdata[11:0];
        REG_MARKER_ENABLE: cfg_d.marker_enable = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.z_min         <= Z_MIN_RST;
      cfg_q.z_scale       <= Z_SCALE_RST;
      cfg_q.frame_width   <= FRAME_WIDTH_RST;
      cfg_q.frame_height  <= FRAME_HEIGHT_RST;
      cfg_q.marker_x      <= '0;
      cfg_q.marker_y      <= '0;
      cfg_q.marker_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_Z_MIN:         prdata = {{16{cfg_q.z_min[15]}}, cfg_q.z_min};
      REG_Z_SCALE:       prdata = {8'd0, cfg_q.z_scale};
      REG_FRAME_WIDTH:   prdata = {19'd0, cfg_q.frame_width};
      REG_FRAME_HEIGHT:  prdata = {19'd0, cfg_q.frame_height};
      REG_MARKER_X:      prdata = {20'd0, cfg_q.marker_x};
      REG_MARKER_Y:      prdata = {20'd0, cfg_q.marker_y};
      REG_MARKER_ENABLE: prdata = {31'd0, cfg_q.marker_enable};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/hmo_scan.sv
// Raster column and row counters with marker and frame-end detection.
module hmo_scan import hmo_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  advance_i,
  input  cfg_t  cfg_i,
  output scan_t scan_o
);

  // Compare widths with one spare bit so that increments cannot wrap.
  localparam int unsigned SIZE_W = ((COORD_BITS > 13) ? COORD_BITS : 13) + 1;
  localparam int unsigned MARK_W = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;

  logic [COORD_BITS-1:0] col_q, col_d, row_q, row_d;
  logic [SIZE_W-1:0]     col_next, row_next;
  logic [MARK_W-1:0]     col_m, row_m, mx_m, my_m;
  logic                  last_col, last_row, near_col, near_row;

  assign col_next = SIZE_W'(col_q) + SIZE_W'(1);
  assign row_next = SIZE_W'(row_q) + SIZE_W'(1);

  // A zero frame size acts as one, and a saturated counter always ends its line.
  assign last_col = (col_next >= SIZE_W'(cfg_i.frame_width)) || (&col_q);
  assign last_row = (row_next >= SIZE_W'(cfg_i.frame_height)) || (&row_q);

  assign col_m = MARK_W'(col_q);
  assign row_m = MARK_W'(row_q);
  assign mx_m  = MARK_W'(cfg_i.marker_x);
  assign my_m  = MARK_W'(cfg_i.marker_y);

  assign near_col = (col_m == mx_m) || (col_m == mx_m + MARK_W'(1)) ||
                    (col_m + MARK_W'(1) == mx_m);
  assign near_row = (row_m == my_m) || (row_m == my_m + MARK_W'(1)) ||
                    (row_m + MARK_W'(1) == my_m);

  assign scan_o.marker_hit = cfg_i.marker_enable & near_col & near_row;
  assign scan_o.frame_end  = last_col & last_row;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_next[COORD_BITS-1:0];
      end else begin
        col_d = col_next[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> rtl/core/hmo_shade.sv
// Color logic between the input register and the result register.
module hmo_shade import hmo_pkg::*; (
  input  stage_t      stage_i,
  input  logic [23:0] z_scale_i,
  output pixel_t      pixel_o
);

  logic [39:0] product;
  logic [7:0]  gray;
  logic [16:0] rem_wide;
  logic [6:0]  rem_raw;
  logic [5:0]  rem;
  logic [7:0]  isl_green;
  logic [8:0]  sum_r, sum_g, sum_b;

  // Only positive differences use the product, and those fit in 16 bits.
  assign product = {24'd0, stage_i.height_diff[15:0]} * {16'd0, z_scale_i};

  always_comb begin
    if (stage_i.height_diff[16] || (stage_i.height_diff == '0)) begin
      gray = '0;
    end else if (|product[39:24]) begin
      gray = GRAY_MAX;
    end else begin
      gray = product[23:16];
    end
  end

  // The stored quotient is exact or one low, so the remainder lies below 120.
  assign rem_wide = {1'b0, stage_i.island_number} -
                    ({6'd0, stage_i.hue_quot} << 6) + ({6'd0, stage_i.hue_quot} << 2);
  assign rem_raw  = rem_wide[6:0];
  assign rem      = (rem_raw >= HUE_PERIOD) ? 6'(rem_raw - HUE_PERIOD) : rem_raw[5:0];
  assign isl_green = island_green(rem);

  assign sum_r = {1'b0, gray} + {1'b0, ISLAND_RED};
  assign sum_g = {1'b0, gray} + {1'b0, isl_green};
  assign sum_b = {1'b0, gray} + {1'b0, ISLAND_BLUE};

  always_comb begin
    pixel_o.frame_end = stage_i.scan.frame_end;
    if (stage_i.scan.marker_hit) begin
      pixel_o.red   = MARKER_RED;
      pixel_o.green = MARKER_GREEN;
      pixel_o.blue  = MARKER_BLUE;
    end else if (stage_i.island_valid) begin
      pixel_o.red   = sum_r[8:1];
      pixel_o.green = sum_g[8:1];
      pixel_o.blue  = sum_b[8:1];
    end else begin
      pixel_o.red   = gray;
      pixel_o.green = gray;
      pixel_o.blue  = gray;
    end
  end

endmodule

>>> rtl/core/heightmap_overlay_pixel_shader.sv
// Heightmap overlay shader: turns raster-order height samples into overlay colors.
//
// Pixels enter on the s_axis channel in raster order, one item per pixel; tdata
// carries the height sample and island number, tuser the island flag. Each item
// gives exactly one colored pixel on the m_axis channel, with tlast high on the
// last pixel of a frame. The block keeps its own column and row counters.
// The accepting edge loads the input register; the result register loads, raising
// m_axis_tvalid, on a later edge when it is free or being taken. One item is
// accepted every cycle while the result register is free or being taken, as both
// registers then advance together. When the receiver stalls, the input register
// still fills, so one further item is taken; after that s_axis_tready drops until
// the result is taken. Reset clears both registers' valid flags, the raster
// counters and the configuration registers (scale 1.0, frame 1x1, marker off).
// Configuration must be written by the user over the APB-style port only while
// no item is in flight; the block itself does not enforce this.
module heightmap_overlay_pixel_shader import hmo_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [31:0]              s_axis_tdata,  // height_sample, island_number
  input  logic                     s_axis_tuser,  // island_valid
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [23:0]              m_axis_tdata,  // red, green, blue
  output logic                     m_axis_tlast,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_t        cfg;
  scan_t       scan;
  stage_t      stage_q, stage_d;
  pixel_t      pixel_q, pixel_d;
  logic        stage_vld_q, stage_vld_d;
  logic        out_vld_q, out_vld_d;
  logic        out_free, accept;
  logic [15:0] height, island_id;
  logic [32:0] quot_prod;

  hmo_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hmo_scan #(
    .COORD_BITS (COORD_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .cfg_i     (cfg),
    .scan_o    (scan)
  );

  hmo_shade u_shade (
    .stage_i   (stage_q),
    .z_scale_i (cfg.z_scale),
    .pixel_o   (pixel_d)
  );

  assign out_free      = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = ~stage_vld_q | out_free;
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign height    = s_axis_tdata[15:0];
  assign island_id = s_axis_tdata[31:16];
  assign quot_prod = {17'd0, island_id} * {16'd0, HUE_RECIP};

  always_comb begin
    stage_d.height_diff   = $signed({height[15], height}) -
                            $signed({cfg.z_min[15], cfg.z_min});
    stage_d.island_valid  = s_axis_tuser;
    stage_d.island_number = island_id;
    stage_d.hue_quot      = quot_prod[HUE_RECIP_SHIFT +: 11];
    stage_d.scan          = scan;
  end

  always_comb begin
    stage_vld_d = stage_vld_q;
    if (accept) begin
      stage_vld_d = 1'b1;
    end else if (out_free) begin
      stage_vld_d = 1'b0;
    end
    out_vld_d = out_free ? stage_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      stage_vld_q <= stage_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
    if (out_free && stage_vld_q) begin
      pixel_q <= pixel_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {pixel_q.blue, pixel_q.green, pixel_q.red};
  assign m_axis_tlast  = pixel_q.frame_end;

endmodule

>>> bench/heightmap_overlay_pixel_shader_tb.sv
// Self-checking heightmap overlay shader bench: directed and random pixels against a predictor.
module heightmap_overlay_pixel_shader_tb import hmo_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_MAX = 4095;
  localparam int unsigned STALL_LIMIT = 4000;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [31:0]              s_axis_tdata = '0;  // height_sample, island_number
  logic                     s_axis_tuser = 1'b0;  // island_valid
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [23:0]              m_axis_tdata;  // red, green, blue
  logic                     m_axis_tlast;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr = '0;
  logic [APB_DATA_BITS-1:0] pwdata = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  heightmap_overlay_pixel_shader i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the configuration registers and of the raster position.
  cfg_t        shadow_cfg = '{z_min: Z_MIN_RST, z_scale: Z_SCALE_RST,
                              frame_width: FRAME_WIDTH_RST, frame_height: FRAME_HEIGHT_RST,
                              marker_x: '0, marker_y: '0, marker_enable: 1'b0};
  logic [11:0] scan_col = '0;
  logic [11:0] scan_row = '0;

  pixel_t      pending_pixels[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_hold = 0;
  bit          steady = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 82) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Colors one pixel and advances the raster position.
  function automatic pixel_t predict_pixel(logic [15:0] height, logic isl, logic [15:0] num);
    pixel_t      px;
    int          diff;
    int          dx;
    int          dy;
    longint      prod;
    int unsigned gray;
    int unsigned hue;
    int unsigned isl_green;
    int unsigned col;
    int unsigned row;
    logic        last_col;
    logic        last_row;
    diff = int'($signed(height)) - int'($signed(shadow_cfg.z_min));
    if (diff <= 0) begin
      gray = 0;
    end else begin
      prod = (longint'(diff) * longint'(shadow_cfg.z_scale)) >>> 16;
      gray = (prod > 255) ? 255 : int'(prod);
    end
    px.red   = 8'(gray);
    px.green = 8'(gray);
    px.blue  = 8'(gray);
    if (isl) begin
      hue = (int'(num) * 37) % 60;
      isl_green = (1453500 + 218025 * hue) / 60000;
      px.red   = 8'((gray + 242) >> 1);
      px.green = 8'((gray + isl_green) >> 1);
      px.blue  = 8'((gray + 24) >> 1);
    end
    col = scan_col;
    row = scan_row;
    dx = int'(col) - int'(shadow_cfg.marker_x);
    dy = int'(row) - int'(shadow_cfg.marker_y);
    if (shadow_cfg.marker_enable && dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1) begin
      px.red   = 8'd0;
      px.green = 8'd255;
      px.blue  = 8'd255;
    end
    last_col = (col + 1 >= shadow_cfg.frame_width) || (col == COORD_MAX);
    last_row = (row + 1 >= shadow_cfg.frame_height) || (row == COORD_MAX);
    px.frame_end = last_col && last_row;
    if (last_col) begin
      scan_col = '0;
      scan_row = last_row ? 12'd0 : 12'(row + 1);
    end else begin
      scan_col = 12'(col + 1);
    end
    return px;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      pending_pixels.push_back(predict_pixel(s_axis_tdata[15:0], s_axis_tuser,
                                             s_axis_tdata[31:16]));
    end
  end

  always @(posedge clk_i) begin : pixel_check
    pixel_t exp_px;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: pixel with nothing expected, actual rgb %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        exp_px = pending_pixels.pop_front();
        if (m_axis_tdata[7:0] !== exp_px.red) begin
          $display("%0t: red expected %0d actual %0d", $time, exp_px.red, m_axis_tdata[7:0]);
          error_count++;
        end
        if (m_axis_tdata[15:8] !== exp_px.green) begin
          $display("%0t: green expected %0d actual %0d", $time, exp_px.green,
                   m_axis_tdata[15:8]);
          error_count++;
        end
        if (m_axis_tdata[23:16] !== exp_px.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, exp_px.blue,
                   m_axis_tdata[23:16]);
          error_count++;
        end
        if (m_axis_tlast !== exp_px.frame_end) begin
          $display("%0t: frame end expected %b actual %b", $time, exp_px.frame_end,
                   m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  // Receiver pacing: runs of ready cycles broken by stalls of random length.
  always @(posedge clk_i) begin : rx_pacing
    int unsigned gap;
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      gap = pick_gap();
      if (gap == 0) begin
        m_axis_tready <= 1'b1;
        rx_hold <= $urandom_range(0, 4);
      end else begin
        m_axis_tready <= 1'b0;
        rx_hold <= gap - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // All tasks start and end right after a rising edge.
  task automatic send_pixel(logic [15:0] height, logic isl, logic [15:0] num);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {num, height};
    s_axis_tuser  <= isl;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_Z_MIN:         shadow_cfg.z_min = value[15:0];
      REG_Z_SCALE:       shadow_cfg.z_scale = value[23:0];
      REG_FRAME_WIDTH:   shadow_cfg.frame_width = value[12:0];
      REG_FRAME_HEIGHT:  shadow_cfg.frame_height = value[12:0];
      REG_MARKER_X:      shadow_cfg.marker_x = value[11:0];
      REG_MARKER_Y:      shadow_cfg.marker_y = value[11:0];
      REG_MARKER_ENABLE: shadow_cfg.marker_enable = value[0];
      default: ;
    endcase
    // The bus goes idle between transfers.
    @(posedge clk_i);
  endtask

  // Settings after reset: unit scale and a 1x1 frame, so every pixel ends a frame.
  task automatic test_reset_state();
    send_pixel(16'h7fff, 1'b0, 16'h0000);
    send_pixel(16'h8000, 1'b1, 16'hffff);
    send_pixel(16'd200, 1'b0, 16'h1234);
    drain_pixels();
  endtask

  task automatic test_gray_range();
    reg_write(REG_Z_MIN, 32'h0000_8000);
    reg_write(REG_Z_SCALE, 32'h00ff_ffff);
    send_pixel(16'h8000, 1'b0, 16'h0000);
    send_pixel(16'h8001, 1'b0, 16'h0000);
    drain_pixels();
    reg_write(REG_Z_MIN, 32'h0000_7fff);
    reg_write(REG_Z_SCALE, 32'h0000_0000);
    send_pixel(16'h7fff, 1'b1, 16'd7);
    send_pixel(16'h8000, 1'b0, 16'hffff);
    drain_pixels();
  endtask

  task automatic test_island_hues();
    reg_write(REG_Z_MIN, 32'h0000_0000);
    reg_write(REG_Z_SCALE, 32'h0001_0000);
    send_pixel(16'd0, 1'b1, 16'd0);
    send_pixel(16'd255, 1'b1, 16'd1);
    send_pixel(16'd100, 1'b1, 16'd59);
    send_pixel(16'd300, 1'b1, 16'hffff);
    drain_pixels();
  endtask

  // Marker on the corner pixel of a 3x2 frame, so part of the block is clipped.
  task automatic test_marker_clip();
    reg_write(REG_FRAME_WIDTH, 32'd3);
    reg_write(REG_FRAME_HEIGHT, 32'd2);
    reg_write(REG_MARKER_X, 32'd0);
    reg_write(REG_MARKER_Y, 32'd0);
    reg_write(REG_MARKER_ENABLE, 32'd1);
    repeat (6) send_pixel(16'($urandom), 1'($urandom), 16'($urandom));
    drain_pixels();
  endtask

  // A frame size of zero behaves as one.
  task automatic test_zero_frame();
    reg_write(REG_FRAME_WIDTH, 32'd0);
    reg_write(REG_FRAME_HEIGHT, 32'd0);
    reg_write(REG_MARKER_ENABLE, 32'd0);
    send_pixel(16'd40, 1'b0, 16'd0);
    send_pixel(16'd41, 1'b1, 16'd2);
    drain_pixels();
  endtask

  task automatic test_random_frames();
    int          zmin;
    int          h;
    int unsigned fw;
    int unsigned fh;
    int unsigned roll;
    logic [23:0] scale;
    for (int ph = 0; ph < 6; ph++) begin
      steady = (ph == 3);
      case ($urandom_range(0, 3))
        0: zmin = -32768;
        1: zmin = 32767;
        default: zmin = int'($urandom_range(0, 65535)) - 32768;
      endcase
      case ($urandom_range(0, 4))
        0: scale = 24'd0;
        1: scale = 24'hffffff;
        2: scale = 24'd65536;
        default: scale = 24'($urandom_range(1, 1 << 20));
      endcase
      roll = $urandom_range(0, 9);
      fw = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      roll = $urandom_range(0, 9);
      fh = (roll == 0) ? 0 : (roll == 1) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      reg_write(REG_Z_MIN, {16'd0, 16'(zmin)});
      reg_write(REG_Z_SCALE, {8'd0, scale});
      reg_write(REG_FRAME_WIDTH, 32'(fw));
      reg_write(REG_FRAME_HEIGHT, 32'(fh));
      reg_write(REG_MARKER_X, 32'($urandom_range(0, fw + 1)));
      reg_write(REG_MARKER_Y, 32'($urandom_range(0, fh + 1)));
      reg_write(REG_MARKER_ENABLE, 32'($urandom_range(0, 3) != 0));
      repeat (72) begin
        roll = $urandom_range(0, 9);
        if (roll < 7) begin
          // Heights around the floor of the map exercise the whole gray ramp.
          h = zmin + int'($urandom_range(0, 600)) - 100;
          if (h > 32767) h = 32767;
          if (h < -32768) h = -32768;
        end else if (roll < 9) begin
          h = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          h = $urandom_range(0, 1) ? 32767 : -32768;
        end
        send_pixel(16'(h), 1'($urandom), 16'($urandom));
      end
      drain_pixels();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_gray_range();
    test_island_hues();
    test_marker_clip();
    test_zero_frame();
    test_random_frames();
    drain_pixels();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> heightmap_overlay_pixel_shader.f
rtl/core/hmo_pkg.sv
rtl/core/hmo_cfg.sv
rtl/core/hmo_scan.sv
rtl/core/hmo_shade.sv
rtl/core/heightmap_overlay_pixel_shader.sv
bench/heightmap_overlay_pixel_shader_tb.sv
